// ===== src/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic       finish;
    logic [7:0] data_byte;
  } cmd_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== src/sha_fifo.sv =====
// Small command queue between the front and the back of the hasher.
`timescale 1ns / 1ps
`default_nettype none
module sha_fifo
  import sha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output logic      empty_o
);
  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoAw:0]   cnt_q;

  assign full_o     = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoAw+1)'(push_i && !full_o) - (FifoAw+1)'(pop_i && !empty_o);
    end
  end
endmodule
`default_nettype wire

// ===== src/sha_front.sv =====
// Input stage: accepts words and classifies them into absorb or finish commands.
`timescale 1ns / 1ps
`default_nettype none
module sha_front
  import sha_pkg::*;
(
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      push_o,
  output cmd_t      push_data_o,
  input  wire logic full_i
);
  assign in_ready_o            = !full_i;
  assign push_o                = in_valid_i && !full_i;
  assign push_data_o.finish    = (op_e'(in_data_i.op) == OP_FINISH);
  assign push_data_o.data_byte = in_data_i.data_byte;
endmodule
`default_nettype wire

// ===== src/sha_back.sv =====
// Back end: block buffer, padding, one-round-per-cycle compression and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha_back
  import sha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      cmd_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_word_t out_data_o
);
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_COMP  = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e       state_q, state_d;
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [5:0]   cnt_q;
  logic [63:0]  total_q;
  logic [5:0]   round_q;
  logic [5:0]   pad_q;
  logic         fin_q;
  logic         len_done_q;
  logic [2:0]   oidx_q;
  logic [7:0]   pad_byte;
  logic [31:0]  wt, w_new, s0, s1, t1, t2, big0, big1, ch, maj;
  logic [63:0]  bits;
  logic [3:0]   wsel;

  assign bits = {total_q[60:0], 3'b000};
  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  // Byte written at pad position: zero, or the length field in the last eight bytes.
  always_comb begin
    pad_byte = 8'h00;
    if (len_done_q && pad_q >= LenOffset)
      pad_byte = bits[8*(7 - 32'(pad_q[2:0])) +: 8];
  end

  assign wsel  = round_q[3:0];
  assign s0    = rotr(w_q[4'(wsel + 4'd1)], 7) ^ rotr(w_q[4'(wsel + 4'd1)], 18)
               ^ (w_q[4'(wsel + 4'd1)] >> 3);
  assign s1    = rotr(w_q[4'(wsel + 4'd14)], 17) ^ rotr(w_q[4'(wsel + 4'd14)], 19)
               ^ (w_q[4'(wsel + 4'd14)] >> 10);
  assign w_new = w_q[wsel] + s0 + w_q[4'(wsel + 4'd9)] + s1;
  assign wt    = (round_q < 6'd16) ? w_q[wsel] : w_new;
  assign big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1    = v_q[7] + big1 + ch + RoundK[round_q] + wt;
  assign big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2    = big0 + maj;

  assign out_valid_o            = (state_q == ST_EMIT);
  assign out_data_o.digest_word = h_q[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.last_word   = (oidx_q == 3'd7);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          // A pad byte in the last slot fills the block, so nothing is left to pad.
          if (cmd_i.finish) state_d = (cnt_q == 6'd63) ? ST_COMP : ST_PAD;
          else if (cnt_q == 6'd63) state_d = ST_COMP;
        end
      end
      ST_PAD:  if (pad_q == 6'd63) state_d = ST_COMP;
      ST_COMP: if (round_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (!fin_q) state_d = ST_IDLE;
        else if (len_done_q) state_d = ST_EMIT;
        else state_d = ST_PAD;
      end
      ST_EMIT: if (out_ready_i && oidx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Word buffer takes one byte at a time into the 16-word window; compression rewrites its schedule words.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && !empty_i) begin
      if (cmd_i.finish) w_q[cnt_q[5:2]][8*(3 - 32'(cnt_q[1:0])) +: 8] <= PadByte;
      else w_q[cnt_q[5:2]][8*(3 - 32'(cnt_q[1:0])) +: 8] <= cmd_i.data_byte;
    end else if (state_q == ST_PAD) begin
      w_q[pad_q[5:2]][8*(3 - 32'(pad_q[1:0])) +: 8] <= pad_byte;
    end else if (state_q == ST_COMP && round_q >= 6'd16) begin
      w_q[wsel] <= w_new;
    end
    if (state_q == ST_COMP) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
      cnt_q      <= '0;
      total_q    <= '0;
      round_q    <= '0;
      pad_q      <= '0;
      fin_q      <= 1'b0;
      len_done_q <= 1'b0;
      oidx_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          round_q <= '0;
          if (!empty_i) begin
            if (cmd_i.finish) begin
              fin_q <= 1'b1;
              // Length goes in this block only when the pad byte lands before byte 56.
              len_done_q <= (cnt_q < LenOffset - 6'd1) || (cnt_q == LenOffset - 6'd1);
              pad_q <= cnt_q + 6'd1;
              if (cnt_q == 6'd63) pad_q <= 6'd63;
            end else begin
              fin_q   <= 1'b0;
              cnt_q   <= cnt_q + 6'd1;
              total_q <= total_q + 64'd1;
            end
          end
        end
        ST_PAD: begin
          if (pad_q != 6'd63) pad_q <= pad_q + 6'd1;
          round_q <= '0;
        end
        ST_COMP: round_q <= round_q + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          cnt_q <= '0;
          if (fin_q && !len_done_q) begin
            len_done_q <= 1'b1;
            pad_q      <= '0;
          end
          oidx_q <= '0;
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
              total_q <= '0;
              fin_q   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one word per item:
// op absorb adds data_byte to the message, op finish pads, compresses and
// emits the digest. Output channel (out_valid_o/out_ready_i/out_data_o)
// carries eight digest words, index 0 (most significant) first, with
// last_word set on index 7.
// A four-entry queue separates intake from the hashing engine, so words are
// taken while the engine compresses or while the receiver stalls.
// An absorb word writes one byte into the block buffer; the 64th byte of a
// block starts 64 compression rounds (one per cycle) and the hash update.
// A finish writes the pad byte, then writes padding into every byte left in
// the block (none when the pad byte fills it, a whole extra block when more
// than 55 bytes are buffered), compresses each block and emits the eight
// digest words. The engine takes no new bytes while it compresses a block;
// its rate is set by the single round unit and the byte-wide buffer writes.
// Reset loads the initial hash values and clears the counters and queue.
// A stalled receiver holds the current digest word until it is taken;
// the engine stops, and intake stops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_word_t out_data_o
);
  logic push, full, pop, empty;
  cmd_t push_data, pop_data;

  sha_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  sha_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  sha_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );
endmodule
`default_nettype wire
